// ===== design/ipv6p_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv6p_pkg
// Shared widths, constants and the hex digit decoder for the IPv6 text
// address parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv6p_pkg;

	localparam int CHAR_W      = 8;
	localparam int GROUP_W     = 16;
	localparam int GROUPS      = 8;
	localparam int DIGITS      = 4;
	localparam int HALF_W      = 64;
	localparam int COUNT_W     = $clog2(GROUPS + 1);
	localparam int GIDX_W      = $clog2(GROUPS);
	localparam int DCOUNT_W    = $clog2(DIGITS + 1);
	localparam int HEX_LETTER_BASE = 10;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;
	localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UC_F  = 8'h46;

	typedef logic [GROUPS-1:0][GROUP_W-1:0] words_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] nib;
	} hex_t;

	// Decode one character as a hex digit
	function automatic hex_t hex_decode(input logic [CHAR_W-1:0] c);
		hex_t              h;
		logic [CHAR_W-1:0] d;
		h = '0;
		d = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
			h.is_hex = 1'b1;
		end else if (c >= CH_LC_A && c <= CH_LC_F) begin
			d = c - CH_LC_A + CHAR_W'(HEX_LETTER_BASE);
			h.is_hex = 1'b1;
		end else if (c >= CH_UC_A && c <= CH_UC_F) begin
			d = c - CH_UC_A + CHAR_W'(HEX_LETTER_BASE);
			h.is_hex = 1'b1;
		end
		h.nib = d[3:0];
		return h;
	endfunction

endpackage

`default_nettype wire

// ===== design/ipv6_text_address_parser_core.sv =====
// ----------------------------------------------------------------------------
// ipv6_text_address_parser_core
// Parses an IPv6 address given as text, one character per input word, and
// emits the 128-bit address with an ok flag when the terminating NUL arrives.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, char_code) carries one ASCII character
//   per word; a NUL (0) ends the string. Output channel (out_valid/out_ready)
//   carries one word per NUL: parse_ok, addr_high (groups 0..3) and addr_low
//   (groups 4..7). On any error parse_ok is 0 and both halves are 0.
//   Every character is handled in the cycle it is accepted: the scan state
//   and an assembled address register update at that edge, so the block takes
//   one character per cycle while no stalled result word holds in_ready low.
//   A NUL's result is in the output register the cycle after it is accepted.
//   Groups before "::" are written straight into their slot; groups after it
//   shift into the low end of the address register, so no search is needed
//   at the end of the string.
//   The output register is a single stage: while it holds a word that the
//   receiver stalls, in_ready is low; when the receiver takes it, a new
//   character can be accepted in the same cycle.
//   Reset (arst_n low) clears the scan state, the address register and the
//   output valid; the block is then at the start of a string.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6_text_address_parser_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [ipv6p_pkg::CHAR_W-1:0]    char_code,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 parse_ok,
	output logic [ipv6p_pkg::HALF_W-1:0]         addr_high,
	output logic [ipv6p_pkg::HALF_W-1:0]         addr_low
);
	import ipv6p_pkg::*;

	// Scan phases
	localparam logic [2:0] PH_START       = 3'd0;
	localparam logic [2:0] PH_LEAD_COLON  = 3'd1;
	localparam logic [2:0] PH_IN_GROUP    = 3'd2;
	localparam logic [2:0] PH_AFTER_COLON = 3'd3;
	localparam logic [2:0] PH_AFTER_GAP   = 3'd4;
	localparam logic [2:0] PH_ERROR       = 3'd5;

	logic [2:0]          phase_q, phase_d;
	logic [COUNT_W-1:0]  count_q, count_d;
	logic                gap_q, gap_d;
	logic [COUNT_W-1:0]  gap_pos_q, gap_pos_d;
	logic [GROUP_W-1:0]  dval_q, dval_d;
	logic [DCOUNT_W-1:0] dcnt_q, dcnt_d;
	words_t              words_q, words_d, words_cmt;

	logic                out_valid_q;
	logic                parse_ok_q;
	words_t              res_words_q;

	logic                in_fire;
	logic                is_nul;
	logic                is_colon;
	logic                room;
	logic                cmt;
	logic                emit_ok;
	hex_t                hx;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign is_nul   = (char_code == CH_NUL);
	assign is_colon = (char_code == CH_COLON);
	assign hx       = hex_decode(char_code);
	assign room     = (count_q < COUNT_W'(GROUPS));

	// Address register with the current group stored: direct slot before
	// the gap, shift into the tail after it
	always_comb begin
		words_cmt = words_q;
		for (int i = 0; i < GROUPS; i++) begin
			if (!gap_q) begin
				if (count_q[GIDX_W-1:0] == GIDX_W'(i)) begin
					words_cmt[i] = dval_q;
				end
			end else if (i == GROUPS - 1) begin
				words_cmt[i] = dval_q;
			end else if (COUNT_W'(i) >= gap_pos_q) begin
				words_cmt[i] = words_q[(i + 1) % GROUPS];
			end
		end
	end

	// Next scan state
	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		gap_d     = gap_q;
		gap_pos_d = gap_pos_q;
		dval_d    = dval_q;
		dcnt_d    = dcnt_q;
		cmt       = 1'b0;
		emit_ok   = 1'b0;
		if (is_nul) begin
			if (phase_q == PH_IN_GROUP) begin
				cmt     = room;
				emit_ok = room && (gap_q || count_q == COUNT_W'(GROUPS - 1));
			end else if (phase_q == PH_AFTER_GAP) begin
				emit_ok = 1'b1;
			end
			phase_d   = PH_START;
			count_d   = '0;
			gap_d     = 1'b0;
			gap_pos_d = '0;
			dval_d    = '0;
			dcnt_d    = '0;
		end else begin
			unique case (phase_q) inside
				PH_START: begin
					if (is_colon) begin
						phase_d = PH_LEAD_COLON;
					end else if (hx.is_hex) begin
						dval_d  = GROUP_W'(hx.nib);
						dcnt_d  = DCOUNT_W'(1);
						phase_d = PH_IN_GROUP;
					end else begin
						phase_d = PH_ERROR;
					end
				end
				PH_LEAD_COLON: begin
					if (is_colon) begin
						gap_d     = 1'b1;
						gap_pos_d = '0;
						phase_d   = PH_AFTER_GAP;
					end else begin
						phase_d = PH_ERROR;
					end
				end
				PH_IN_GROUP: begin
					if (hx.is_hex) begin
						if (dcnt_q >= DCOUNT_W'(DIGITS)) begin
							phase_d = PH_ERROR;
						end else begin
							dval_d = {dval_q[GROUP_W-5:0], hx.nib};
							dcnt_d = dcnt_q + DCOUNT_W'(1);
						end
					end else if (is_colon && room) begin
						cmt     = 1'b1;
						count_d = count_q + COUNT_W'(1);
						dval_d  = '0;
						dcnt_d  = '0;
						phase_d = PH_AFTER_COLON;
					end else begin
						phase_d = PH_ERROR;
					end
				end
				PH_AFTER_COLON, PH_AFTER_GAP: begin
					if (hx.is_hex) begin
						if (room) begin
							dval_d  = GROUP_W'(hx.nib);
							dcnt_d  = DCOUNT_W'(1);
							phase_d = PH_IN_GROUP;
						end else begin
							phase_d = PH_ERROR;
						end
					end else if (is_colon && !gap_q && phase_q == PH_AFTER_COLON) begin
						gap_d     = 1'b1;
						gap_pos_d = count_q;
						phase_d   = PH_AFTER_GAP;
					end else begin
						phase_d = PH_ERROR;
					end
				end
				default: begin
					phase_d = PH_ERROR;
				end
			endcase
		end
		if (is_nul) begin
			words_d = '0;
		end else begin
			words_d = cmt ? words_cmt : words_q;
		end
	end

	// Scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			count_q   <= '0;
			gap_q     <= 1'b0;
			gap_pos_q <= '0;
			dval_q    <= '0;
			dcnt_q    <= '0;
			words_q   <= '0;
		end else if (in_fire) begin
			phase_q   <= phase_d;
			count_q   <= count_d;
			gap_q     <= gap_d;
			gap_pos_q <= gap_pos_d;
			dval_q    <= dval_d;
			dcnt_q    <= dcnt_d;
			words_q   <= words_d;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && is_nul) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (in_fire && is_nul) begin
			parse_ok_q <= emit_ok;
			if (!emit_ok) begin
				res_words_q <= '0;
			end else begin
				res_words_q <= cmt ? words_cmt : words_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign parse_ok  = parse_ok_q;
	assign addr_high = {res_words_q[0], res_words_q[1], res_words_q[2], res_words_q[3]};
	assign addr_low  = {res_words_q[4], res_words_q[5], res_words_q[6], res_words_q[7]};

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(GROUPS))
		else $error("group count above eight");

	a_group_digits: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IN_GROUP |-> dcnt_q >= DCOUNT_W'(1) && dcnt_q <= DCOUNT_W'(DIGITS))
		else $error("group digit count out of range");

	a_gap_pos: assert property (@(posedge clk) disable iff (!arst_n)
		gap_pos_q <= count_q)
		else $error("gap position beyond stored groups");

	a_nul_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && is_nul |=> phase_q == PH_START && count_q == '0 && !gap_q && out_valid)
		else $error("NUL did not restart scan and raise a result");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !parse_ok |-> addr_high == '0 && addr_low == '0)
		else $error("failed parse with nonzero address");
`endif

endmodule

`default_nettype wire

// ===== sim/ipv6_text_address_parser_core_test.sv =====
// ----------------------------------------------------------------------------
// ipv6_text_address_parser_core_test
// Sends IPv6 address strings to the parser one character per word: a short
// table of hand-picked strings first, then random strings. Most random
// strings are well formed, some are damaged and some are noise. Each result
// word is checked against a scan model kept in the bench, or against the
// table's result for a row with typed set. Both channels idle in random bursts.
// ----------------------------------------------------------------------------

module ipv6_text_address_parser_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	import ipv6p_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_CHARS = 1250;
	localparam int NUM_ROWS = 24;
	localparam int TAIL_CYCLES = 8;

	typedef enum logic [2:0] {
		SCAN_START       = 3'd0,
		SCAN_LEAD_COLON  = 3'd1,
		SCAN_IN_GROUP    = 3'd2,
		SCAN_AFTER_COLON = 3'd3,
		SCAN_AFTER_GAP   = 3'd4,
		SCAN_ERROR       = 3'd5
	} scan_t;

	typedef struct packed {
		logic              ok;
		logic [HALF_W-1:0] high;
		logic [HALF_W-1:0] low;
	} addr_result_t;

	typedef struct packed {
		bit           typed;
		addr_result_t res;
	} row_check_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [CHAR_W-1:0]   char_code = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                parse_ok;
	logic [HALF_W-1:0]   addr_high;
	logic [HALF_W-1:0]   addr_low;

	ipv6_text_address_parser_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.parse_ok  (parse_ok),
		.addr_high (addr_high),
		.addr_low  (addr_low)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Scan model state
	logic [GROUP_W-1:0] grp_mem [GROUPS];
	logic [3:0]         grp_cnt;
	logic               gap_flag;
	logic [3:0]         gap_at;
	logic [GROUP_W-1:0] cur_val;
	logic [2:0]         cur_digits;
	scan_t              phase;

	addr_result_t       result_q [$];
	logic [CHAR_W-1:0]  text_buf [$];
	int                 mismatch_count = 0;
	int                 cycle_count = 0;
	int                 stall_left = 0;
	bit                 in_idle_en = 1'b0;
	bit                 out_idle_en = 1'b0;
	addr_result_t       want;

	// Hand-picked strings; a row with typed set carries its result
	string dir_text [NUM_ROWS] = '{
		"",
		"::",
		"1:2:3:4:5:6:7:8",
		"ffff:FFFF:fFfF:ABCD:abcd:0:9:0000",
		":1",
		":",
		"12345::",
		"1:g",
		"@",
		"1:\377",
		":::",
		"1::2::3",
		"1:2:3:4:5:6:7:",
		"1:2:3:4:5:6:7:8:9",
		"1:2:3:4::5:6:7:8",
		"1:2:3:4:5:6:7:8::",
		"::1:2:3:4:5:6:7:8",
		"1:2:3:4:5:6:7:8::9",
		"1:2:3",
		"1::",
		"::abcd",
		"a:b::e:f",
		"1:g::\n",
		"0:00:000:0000:9999:FfFf:aBc:/"
	};

	row_check_t dir_check [NUM_ROWS] = '{
		'{1'b1, '{1'b0, 64'h0, 64'h0}},
		'{1'b1, '{1'b1, 64'h0, 64'h0}},
		'{1'b1, '{1'b1, 64'h0001_0002_0003_0004, 64'h0005_0006_0007_0008}},
		'{1'b1, '{1'b1, 64'hffff_ffff_ffff_abcd, 64'habcd_0000_0009_0000}},
		'{1'b1, '{1'b0, 64'h0, 64'h0}},
		'{1'b1, '{1'b0, 64'h0, 64'h0}},
		'{1'b1, '{1'b0, 64'h0, 64'h0}},
		'{1'b1, '{1'b0, 64'h0, 64'h0}},
		'{1'b1, '{1'b0, 64'h0, 64'h0}},
		'{1'b1, '{1'b0, 64'h0, 64'h0}},
		'{1'b1, '{1'b0, 64'h0, 64'h0}},
		'{1'b1, '{1'b0, 64'h0, 64'h0}},
		'{1'b1, '{1'b0, 64'h0, 64'h0}},
		'{1'b1, '{1'b0, 64'h0, 64'h0}},
		'{1'b0, '{1'b0, 64'h0, 64'h0}},
		'{1'b0, '{1'b0, 64'h0, 64'h0}},
		'{1'b0, '{1'b0, 64'h0, 64'h0}},
		'{1'b1, '{1'b0, 64'h0, 64'h0}},
		'{1'b1, '{1'b0, 64'h0, 64'h0}},
		'{1'b1, '{1'b1, 64'h0001_0000_0000_0000, 64'h0}},
		'{1'b0, '{1'b0, 64'h0, 64'h0}},
		'{1'b0, '{1'b0, 64'h0, 64'h0}},
		'{1'b1, '{1'b0, 64'h0, 64'h0}},
		'{1'b1, '{1'b0, 64'h0, 64'h0}}
	};

	// Hex value of a character, -1 if it is not a hex digit
	function automatic int nibble_of(input logic [CHAR_W-1:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
		if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
		if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
		return -1;
	endfunction

	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 4'd10) return CH_ZERO + CHAR_W'(v);
		return (upper ? CH_UC_A : CH_LC_A) + CHAR_W'(v - 4'd10);
	endfunction

	function automatic void clear_scan();
		grp_cnt = '0;
		gap_flag = 1'b0;
		gap_at = '0;
		cur_val = '0;
		cur_digits = '0;
		phase = SCAN_START;
	endfunction

	// First digit of a new group; no room after eight groups
	function automatic void open_group(input int nib);
		if (grp_cnt >= GROUPS) begin
			phase = SCAN_ERROR;
			return;
		end
		cur_val = GROUP_W'(nib);
		cur_digits = 3'd1;
		phase = SCAN_IN_GROUP;
	endfunction

	function automatic bit store_group();
		if (grp_cnt >= GROUPS) return 1'b0;
		grp_mem[grp_cnt[2:0]] = cur_val;
		grp_cnt = grp_cnt + 4'd1;
		cur_val = '0;
		cur_digits = '0;
		return 1'b1;
	endfunction

	// End of string: place head and tail groups around the gap
	function automatic addr_result_t close_string(input bit ok_in);
		logic [GROUP_W-1:0] words [GROUPS];
		addr_result_t       r;
		bit                 ok;
		int                 head;
		int                 tail;
		ok = ok_in;
		r = '0;
		for (int i = 0; i < GROUPS; i++) words[i] = '0;
		if (ok && !gap_flag && grp_cnt != GROUPS) ok = 1'b0;
		if (ok && gap_at > grp_cnt) ok = 1'b0;
		if (ok) begin
			head = gap_flag ? int'(gap_at) : int'(grp_cnt);
			tail = int'(grp_cnt) - head;
			for (int i = 0; i < head; i++) words[i] = grp_mem[i];
			for (int i = 0; i < tail; i++) words[GROUPS - tail + i] = grp_mem[head + i];
			r.high = {words[0], words[1], words[2], words[3]};
			r.low = {words[4], words[5], words[6], words[7]};
		end
		r.ok = ok;
		clear_scan();
		return r;
	endfunction

	// Advance the scan model by one character
	task automatic scan_char(input logic [CHAR_W-1:0] c, output bit done,
			output addr_result_t res);
		int nib;
		bit is_colon;
		nib = nibble_of(c);
		is_colon = (c == CH_COLON);
		done = 1'b0;
		res = '0;
		if (c == CH_NUL) begin
			done = 1'b1;
			case (phase)
				SCAN_IN_GROUP:  res = close_string(store_group());
				SCAN_AFTER_GAP: res = close_string(1'b1);
				default:        res = close_string(1'b0);
			endcase
			return;
		end
		case (phase)
			SCAN_START: begin
				if (is_colon) phase = SCAN_LEAD_COLON;
				else if (nib >= 0) open_group(nib);
				else phase = SCAN_ERROR;
			end
			SCAN_LEAD_COLON: begin
				if (is_colon) begin
					gap_flag = 1'b1;
					gap_at = '0;
					phase = SCAN_AFTER_GAP;
				end else begin
					phase = SCAN_ERROR;
				end
			end
			SCAN_IN_GROUP: begin
				if (nib >= 0) begin
					if (cur_digits >= DIGITS) begin
						phase = SCAN_ERROR;
					end else begin
						cur_val = {cur_val[GROUP_W-5:0], 4'(nib)};
						cur_digits = cur_digits + 3'd1;
					end
				end else if (is_colon) begin
					phase = store_group() ? SCAN_AFTER_COLON : SCAN_ERROR;
				end else begin
					phase = SCAN_ERROR;
				end
			end
			SCAN_AFTER_COLON: begin
				if (nib >= 0) begin
					open_group(nib);
				end else if (is_colon && !gap_flag) begin
					gap_flag = 1'b1;
					gap_at = grp_cnt;
					phase = SCAN_AFTER_GAP;
				end else begin
					phase = SCAN_ERROR;
				end
			end
			SCAN_AFTER_GAP: begin
				if (nib >= 0) open_group(nib);
				else phase = SCAN_ERROR;
			end
			default: phase = SCAN_ERROR;
		endcase
	endtask

	// Send one character word; queue the result when it ends a string
	task automatic send_char(input logic [CHAR_W-1:0] c, input bit use_typed,
			input addr_result_t typed_res);
		bit           got;
		addr_result_t pred;
		if (in_idle_en && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		scan_char(c, got, pred);
		if (got) result_q.push_back(use_typed ? typed_res : pred);
	endtask

	// Hold the input until every queued result has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
	endtask

	task automatic push_group();
		int ndig;
		ndig = ($urandom_range(0, 2) == 0) ? 4 : $urandom_range(1, 4);
		repeat (ndig) text_buf.push_back(hex_char(4'($urandom_range(0, 15)),
			bit'($urandom_range(0, 1))));
	endtask

	// Random string: mostly well formed, some damaged, some noise
	task automatic make_text();
		int  kind;
		int  n;
		int  gap_pos;
		int  pos;
		bit  use_gap;
		text_buf.delete();
		kind = $urandom_range(0, 19);
		if (kind < 2) begin
			repeat ($urandom_range(0, 10)) text_buf.push_back(CHAR_W'($urandom_range(1, 255)));
		end else begin
			use_gap = $urandom_range(0, 2) != 0;
			if (use_gap) n = $urandom_range(0, 8);
			else n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 9) : 8;
			gap_pos = $urandom_range(0, n);
			for (int i = 0; i < n; i++) begin
				if (use_gap && i == gap_pos) begin
					text_buf.push_back(CH_COLON);
					text_buf.push_back(CH_COLON);
				end else if (i > 0) begin
					text_buf.push_back(CH_COLON);
				end
				push_group();
			end
			if (use_gap && gap_pos == n) begin
				text_buf.push_back(CH_COLON);
				text_buf.push_back(CH_COLON);
			end
			// damage about a fifth of the well-formed strings
			if (kind < 6) begin
				pos = $urandom_range(0, text_buf.size());
				case ($urandom_range(0, 4))
					0: text_buf.insert(pos, CHAR_W'($urandom_range(1, 255)));
					1: if (pos < text_buf.size()) text_buf.delete(pos);
					2: begin
						if (pos < text_buf.size()) text_buf[pos] = CHAR_W'($urandom_range(1, 255));
					end
					3: text_buf.insert(pos, CH_COLON);
					default: text_buf.insert(pos, hex_char(4'($urandom_range(0, 15)), 1'b0));
				endcase
			end
		end
		text_buf.push_back(CH_NUL);
	endtask

	// Output side: random stalls and result check
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected word: ok=%0b high=%h low=%h",
						parse_ok, addr_high, addr_low);
			end else begin
				want = result_q.pop_front();
				if (parse_ok !== want.ok || addr_high !== want.high || addr_low !== want.low) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("word mismatch: exp ok=%0b high=%h low=%h got ok=%0b high=%h low=%h",
							want.ok, want.high, want.low, parse_ok, addr_high, addr_low);
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (out_idle_en && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 6) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ipv6_text_address_parser_core: mismatch");
		$finish;
	end

	// Stimulus
	initial begin
		int random_sent;
		bit pressure_done;
		random_sent = 0;
		pressure_done = 1'b0;
		for (int i = 0; i < GROUPS; i++) grp_mem[i] = '0;
		clear_scan();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings
		for (int r = 0; r < NUM_ROWS; r++) begin
			in_idle_en = $urandom_range(0, 2) != 0;
			out_idle_en = $urandom_range(0, 2) != 0;
			for (int k = 0; k < dir_text[r].len(); k++)
				send_char(CHAR_W'(dir_text[r][k]), 1'b0, '0);
			send_char(CH_NUL, dir_check[r].typed, dir_check[r].res);
		end
		drain_results();

		// random strings; no idling near the end
		while (random_sent < RANDOM_CHARS) begin
			make_text();
			if (random_sent > RANDOM_CHARS - 200) begin
				in_idle_en = 1'b0;
				out_idle_en = 1'b0;
			end else begin
				in_idle_en = $urandom_range(0, 3) != 0;
				out_idle_en = $urandom_range(0, 3) != 0;
			end
			foreach (text_buf[i]) send_char(text_buf[i], 1'b0, '0);
			random_sent += text_buf.size();
			if (!pressure_done && random_sent >= RANDOM_CHARS / 2) begin
				drain_results();
				pressure_done = 1'b1;
			end
		end

		in_valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && result_q.size() == 0) begin
			$display("ipv6_text_address_parser_core: match");
		end else begin
			$display("ipv6_text_address_parser_core: mismatch");
		end
		$finish;
	end

endmodule
